### sv/pafl_pkg.sv
// pafl_pkg: shared types, widths and helpers for the pool allocator free list
// no dependencies; imported by every module of the block
package pafl_pkg;

	// free stack geometry and node alignment
	localparam int unsigned FREE_DEPTH = 256;
	localparam int unsigned NODE_ALIGN = 8;
	localparam int unsigned MIN_NODE_BYTES = 8;

	localparam int unsigned IDX_W = $clog2(FREE_DEPTH);
	localparam int unsigned CNT_W = $clog2(FREE_DEPTH + 1);

	// field widths
	localparam int unsigned MODE_W = 2;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned LEN_W = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned NB_W = 17;
	localparam int unsigned NSZ_W = 18;
	localparam int unsigned REG_W = 33;

	// stream beat widths, whole bytes
	localparam int unsigned IN_BITS = MODE_W + ADDR_W + LEN_W;
	localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS = ADDR_W + STATUS_W;
	localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_GROW  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_EXHAUSTED    = 3'd1,
		ST_TOO_LARGE    = 3'd2,
		ST_STACK_FULL   = 3'd3,
		ST_GROW_REFUSED = 3'd4
	} status_t;

	// control from the decision logic to the free stack
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [ADDR_W-1:0] wdata;
	} stack_cmd_t;

	// free stack status seen by the decision logic
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [ADDR_W-1:0] top;
	} stack_stat_t;

	// one result item
	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] node_address;
	} result_t;

	// node size clamped to the minimum, then rounded up to the alignment
	function automatic logic [NSZ_W-1:0] round_node_bytes(input logic [NB_W-1:0] nb);
		logic [NSZ_W-1:0] n;
		logic [NSZ_W-1:0] r;
		n = (nb < NB_W'(MIN_NODE_BYTES)) ? NSZ_W'(MIN_NODE_BYTES) : NSZ_W'(nb);
		r = NSZ_W'(((n + NSZ_W'(NODE_ALIGN - 1)) / NODE_ALIGN) * NODE_ALIGN);
		return r;
	endfunction

endpackage

### sv/pool_allocator_free_list_top.sv
// Fixed-size node pool allocator: one input register, one result register.
// A request beat passes the input register, is decided combinationally and shown on m_tvalid
// from the result register; throughput one beat per cycle while m_tready does not stall.
// The free stack pop uses a cached top plus a read-ahead of the memory port.
// Reset clears the fill level, the region bounds and sets node size to 8;
// stack memory is left undefined and needs no clearing pass.
module pool_allocator_free_list_top
	import pafl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [NB_W-1:0]       cfg_data,     // node_bytes
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,      // mode, address, length, zero fill
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata       // node_address, status, zero fill
);

	logic              valid_s1;
	mode_t             mode_s1;
	logic [ADDR_W-1:0] address_s1;
	logic [LEN_W-1:0]  length_s1;
	logic              valid_s2;
	result_t           result_s2;

	logic              s2_ready;
	logic              en;
	stack_cmd_t        cmd;
	stack_stat_t       stat;
	result_t           result;

	// pipeline handshake
	assign s2_ready = !valid_s2 || m_tready;
	assign en       = valid_s1 && s2_ready;
	assign s_tready = !valid_s1 || s2_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1    <= mode_t'(s_tdata[MODE_W-1:0]);
			address_s1 <= s_tdata[MODE_W +: ADDR_W];
			length_s1  <= s_tdata[MODE_W + ADDR_W +: LEN_W];
		end
	end

	pafl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.en       (en),
		.mode     (mode_s1),
		.address  (address_s1),
		.length   (length_s1),
		.stat     (stat),
		.cmd      (cmd),
		.result   (result)
	);

	pafl_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s2 <= result;
		end
	end

	// output beat
	assign m_tvalid = valid_s2;
	assign m_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), result_s2.status,
		result_s2.node_address};

endmodule

### sv/pafl_stack.sv
// pafl_stack: bounded lifo of freed node addresses, memory plus cached top
// depends on pafl_pkg
module pafl_stack
	import pafl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  stack_cmd_t  cmd,
	output stack_stat_t stat
);

	logic [ADDR_W-1:0] mem [FREE_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic [CNT_W-1:0]  rd_ext;
	logic [IDX_W-1:0]  rd_addr;
	logic [ADDR_W-1:0] rd_q;
	logic [ADDR_W-1:0] top_q;

	// next fill level
	always_comb begin
		count_nxt = count_q;
		if (cmd.push) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// read ahead the entry under the next top, never the entry written now
	assign rd_ext  = count_nxt - CNT_W'(2);
	assign rd_addr = rd_ext[IDX_W-1:0];

	// storage array with registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[count_q[IDX_W-1:0]] <= cmd.wdata;
		end
		rd_q <= mem[rd_addr];
	end

	// fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// cached top entry
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= cmd.wdata;
		end else if (cmd.pop) begin
			top_q <= rd_q;
		end
	end

	assign stat.count = count_q;
	assign stat.top   = top_q;

	// checks
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (count_q < CNT_W'(FREE_DEPTH)) && !cmd.pop)
		else $error("push on a full stack or together with pop");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> count_q != '0)
		else $error("pop on an empty stack");

	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> top_q == $past(cmd.wdata))
		else $error("cached top does not follow the pushed address");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not lower the fill level");

endmodule

### sv/pafl_ctrl.sv
// pafl_ctrl: node size register, bump region and per-request decision logic
// depends on pafl_pkg; drives pafl_stack through stack_cmd_t
module pafl_ctrl
	import pafl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [NB_W-1:0]   cfg_data,
	input  logic              en,
	input  mode_t             mode,
	input  logic [ADDR_W-1:0] address,
	input  logic [LEN_W-1:0]  length,
	input  stack_stat_t       stat,
	output stack_cmd_t        cmd,
	output result_t           result
);

	logic [NSZ_W-1:0] nsz_q;
	logic [REG_W-1:0] next_q;
	logic [REG_W-1:0] end_q;

	logic [REG_W:0]   bump_sum;
	logic             bump_ok;
	logic [REG_W-1:0] left;
	logic             do_push;
	logic             do_pop;
	logic             do_bump;
	logic             do_grow;

	// effective node size, worked out when written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nsz_q <= round_node_bytes(NB_W'(MIN_NODE_BYTES));
		end else if (cfg_we) begin
			nsz_q <= round_node_bytes(cfg_data);
		end
	end

	// bump pointer checks
	assign bump_sum = {1'b0, next_q} + (REG_W + 1)'(nsz_q);
	assign bump_ok  = (bump_sum <= {1'b0, end_q}) && !next_q[REG_W-1];
	assign left     = (end_q >= next_q) ? (end_q - next_q) : '0;

	// request decision
	always_comb begin
		do_push = 1'b0;
		do_pop  = 1'b0;
		do_bump = 1'b0;
		do_grow = 1'b0;
		result.status       = ST_OK;
		result.node_address = '0;
		case (mode)
			MODE_ALLOC: begin
				if (length > LEN_W'(nsz_q)) begin
					result.status = ST_TOO_LARGE;
				end else if (stat.count != '0) begin
					do_pop = 1'b1;
					result.node_address = stat.top;
				end else if (bump_ok) begin
					do_bump = 1'b1;
					result.node_address = next_q[ADDR_W-1:0];
				end else begin
					result.status = ST_EXHAUSTED;
				end
			end
			MODE_FREE: begin
				if (stat.count >= CNT_W'(FREE_DEPTH)) begin
					result.status = ST_STACK_FULL;
				end else begin
					do_push = 1'b1;
				end
			end
			MODE_GROW: begin
				if (left >= REG_W'(nsz_q)) begin
					result.status = ST_GROW_REFUSED;
				end else begin
					do_grow = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd.push  = en && do_push;
	assign cmd.pop   = en && do_pop;
	assign cmd.wdata = address;

	// region bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
			end_q  <= '0;
		end else if (en && do_bump) begin
			next_q <= bump_sum[REG_W-1:0];
		end else if (en && do_grow) begin
			next_q <= REG_W'(address);
			end_q  <= REG_W'(address) + REG_W'(length);
		end
	end

endmodule
